@@ hw/rtl/ppg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes, constants and ROM builders for the plasma pixel generator.
// Depends on nothing; used by plasma_pixel_generator_unit and its testbench.
package ppg_pkg;

	// Field widths and fixed sizes
	localparam int unsigned COORD_BITS        = 9;
	localparam int unsigned MS_IN_BITS        = 16;
	localparam int unsigned MS_BITS           = 7;
	localparam int unsigned MAX_MS            = 100;
	localparam int unsigned MAX_SIDE          = 320;
	localparam int unsigned PALETTE_ENTRIES   = 256;
	localparam int unsigned PAL_BITS          = $clog2(PALETTE_ENTRIES);
	localparam int unsigned SINE_INDEX_BITS   = 10;
	localparam int unsigned PHASE_BITS        = 32;
	localparam int unsigned PAL_PHASE_BITS    = 24;
	localparam int unsigned APB_ADDR_BITS     = 5;
	localparam int unsigned APB_DATA_BITS     = 32;

	// Largest coordinate kept; anything above is clamped to it
	localparam int unsigned SIDE_LIM = (MAX_SIDE - 1 > (1 << COORD_BITS) - 1) ?
		(1 << COORD_BITS) - 1 : MAX_SIDE - 1;
	localparam logic [COORD_BITS-1:0] COORD_LIM = COORD_BITS'(SIDE_LIM);

	// Request actions
	typedef enum logic {
		ACT_TICK  = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	// Register slots on the APB port, 4 bytes apart
	typedef enum logic [2:0] {
		REG_COL_STEP     = 3'd0,
		REG_ROW_STEP     = 3'd1,
		REG_DIAG_STEP    = 3'd2,
		REG_RATE_COL     = 3'd3,
		REG_RATE_ROW     = 3'd4,
		REG_RATE_DIAG    = 3'd5,
		REG_RATE_PALETTE = 3'd6
	} reg_idx_t;

	localparam int unsigned REG_COUNT = 7;

	// Register reset values
	localparam logic [31:0] COL_STEP_RST     = 32'd40265318;
	localparam logic [31:0] ROW_STEP_RST     = 32'd40265318;
	localparam logic [31:0] DIAG_STEP_RST    = 32'd13443077;
	localparam logic [31:0] RATE_COL_RST     = 32'd533181;
	localparam logic [31:0] RATE_ROW_RST     = 32'd451153;
	localparam logic [31:0] RATE_DIAG_RST    = 32'd369125;
	localparam logic [23:0] RATE_PALETTE_RST = 24'd3932;

	// Angle constants, 2^32 units per turn; 2*pi in Q30
	localparam logic [31:0] THIRD_TURN     = 32'd1431655765;
	localparam logic [31:0] TWO_THIRD_TURN = 32'd2863311531;
	localparam logic [63:0] TWO_PI_Q30     = 64'd6746518852;

	typedef struct packed {
		logic                  action;
		logic [MS_IN_BITS-1:0] elapsed_ms;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef rgb_t [PALETTE_ENTRIES-1:0] pal_rom_t;

	// floor(255*(0.5+0.5*sin(angle))), sine by quadrant fold and Taylor series in Q30
	function automatic logic [7:0] unit_of_angle(input logic [31:0] angle);
		logic [63:0] r;
		logic [63:0] theta;
		logic [63:0] sq;
		logic [63:0] term;
		logic [63:0] prod;
		longint      s;
		longint      v;
		r = {34'd0, angle[29:0]};
		if (angle[30]) begin
			r = 64'h4000_0000 - r;
		end
		theta = (r * TWO_PI_Q30) >> 32;
		sq    = (theta * theta) >> 30;
		term  = theta;
		s     = longint'(theta);
		term  = ((term * sq) >> 30) / 64'd6;
		s     = s - longint'(term);
		term  = ((term * sq) >> 30) / 64'd20;
		s     = s + longint'(term);
		term  = ((term * sq) >> 30) / 64'd42;
		s     = s - longint'(term);
		term  = ((term * sq) >> 30) / 64'd72;
		s     = s + longint'(term);
		term  = ((term * sq) >> 30) / 64'd110;
		s     = s - longint'(term);
		term  = ((term * sq) >> 30) / 64'd156;
		s     = s + longint'(term);
		term  = ((term * sq) >> 30) / 64'd210;
		s     = s - longint'(term);
		if (angle[31]) begin
			s = -s;
		end
		v = (longint'(1) << 30) + s;
		if (v < 0) begin
			v = 0;
		end
		if (v > (longint'(1) << 31)) begin
			v = longint'(1) << 31;
		end
		prod = (64'(v) * 64'd255) >> 31;
		return prod[7:0];
	endfunction

	// Rainbow palette: three sines a third of a turn apart
	function automatic pal_rom_t palette_table();
		pal_rom_t    t;
		logic [31:0] a;
		for (int k = 0; k < PALETTE_ENTRIES; k++) begin
			a = 32'(k) << (32 - PAL_BITS);
			t[k].red   = unit_of_angle(a);
			t[k].green = unit_of_angle(a + THIRD_TURN);
			t[k].blue  = unit_of_angle(a + TWO_THIRD_TURN);
		end
		return t;
	endfunction

	localparam pal_rom_t PALETTE_ROM = palette_table();

endpackage

@@ hw/rtl/plasma_pixel_generator_unit.sv @@
`timescale 1ns / 1ps
// Plasma pixel generator: phase accumulators, three sine ROM lanes, palette ROM, APB registers.
// Depends on ppg_pkg for payload types, codes, constants and ROM contents.
// Pipeline: after acceptance into the input register, a pixel transaction passes the angle,
// sine ROM read and palette/output registers before its color appears on rgb. Throughput:
// one transaction per cycle; each stage holds only while the stage after it is full and
// stalled, so input is still taken while a finished color waits if an earlier stage is empty.
// A tick updates the phases as it leaves the input register and yields no color.
// Reset (arst_n low, asynchronous) clears all valid flags and phases and loads register defaults.
module plasma_pixel_generator_unit #(
	parameter int unsigned SINE_INDEX_BITS = ppg_pkg::SINE_INDEX_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               req_valid,
	output logic                               req_ready,
	input  ppg_pkg::req_t                      req,
	// color channel
	output logic                               rgb_valid,
	input  logic                               rgb_ready,
	output ppg_pkg::rgb_t                      rgb,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ppg_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [ppg_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [ppg_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	localparam int unsigned SINE_ENTRIES = 1 << SINE_INDEX_BITS;
	localparam int unsigned LANES        = 3;

	// Configuration registers
	logic [31:0] col_step_q, row_step_q, diag_step_q;
	logic [31:0] rate_col_q, rate_row_q, rate_diag_q;
	logic [23:0] rate_palette_q;

	// Phase state
	logic [ppg_pkg::PHASE_BITS-1:0]     phase_col_q, phase_row_q, phase_diag_q;
	logic [ppg_pkg::PAL_PHASE_BITS-1:0] palette_q;

	// Pipeline
	logic                              valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                              action_s1;
	logic [ppg_pkg::MS_BITS-1:0]       ms_s1;
	logic [ppg_pkg::COORD_BITS-1:0]    x_s1, y_s1;
	logic [SINE_INDEX_BITS-1:0]        idx_s2 [LANES];
	logic [ppg_pkg::PAL_BITS-1:0]      pal_s2, pal_s3;
	logic [7:0]                        sine_s3 [LANES];
	ppg_pkg::rgb_t                     rgb_q;

	logic                              take_s1, take_s2, take_s3, take_out;
	logic                              cfg_wr;
	logic [ppg_pkg::MS_BITS-1:0]       ms_sat;
	logic [ppg_pkg::COORD_BITS-1:0]    x_sat, y_sat;
	logic [ppg_pkg::COORD_BITS:0]      xy_sum;
	logic [31:0]                       ang [LANES];
	logic [ppg_pkg::PAL_BITS-1:0]      pal_idx;
	logic [7:0]                        sine_tab [LANES][SINE_ENTRIES];

	// Sine ROM, one copy per lane so each has a single read port
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_entry
			assign sine_tab[g][i] =
				ppg_pkg::unit_of_angle(32'(i) << (32 - SINE_INDEX_BITS));
		end
	end

	// Stage advance: a stage loads when empty or when its content moves on
	assign take_out  = !out_valid_q || rgb_ready;
	assign take_s3   = !valid_s3 || take_out;
	assign take_s2   = !valid_s2 || take_s3;
	assign take_s1   = !valid_s1 || take_s2;
	assign req_ready = take_s1;
	assign rgb_valid = out_valid_q;
	assign rgb       = rgb_q;

	// Clamp elapsed time and coordinates
	assign ms_sat = (req.elapsed_ms > ppg_pkg::MS_IN_BITS'(ppg_pkg::MAX_MS)) ?
		ppg_pkg::MS_BITS'(ppg_pkg::MAX_MS) : req.elapsed_ms[ppg_pkg::MS_BITS-1:0];
	assign x_sat = (req.pos_x > ppg_pkg::COORD_LIM) ? ppg_pkg::COORD_LIM : req.pos_x;
	assign y_sat = (req.pos_y > ppg_pkg::COORD_LIM) ? ppg_pkg::COORD_LIM : req.pos_y;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			action_s1 <= req.action;
			ms_s1     <= ms_sat;
			x_s1      <= x_sat;
			y_s1      <= y_sat;
		end
	end

	// Form the three angles from the current phases
	assign xy_sum = {1'b0, x_s1} + {1'b0, y_s1};
	assign ang[0] = phase_col_q + 32'(col_step_q * x_s1);
	assign ang[1] = phase_row_q + 32'(row_step_q * y_s1);
	assign ang[2] = phase_diag_q + 32'(diag_step_q * xy_sum);

	// Advance phases when a tick leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_col_q  <= '0;
			phase_row_q  <= '0;
			phase_diag_q <= '0;
			palette_q    <= '0;
			valid_s2     <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1 && (action_s1 == ppg_pkg::ACT_PIXEL);
			if (valid_s1 && (action_s1 == ppg_pkg::ACT_TICK)) begin
				phase_col_q  <= phase_col_q + 32'(rate_col_q * ms_s1);
				phase_row_q  <= phase_row_q + 32'(rate_row_q * ms_s1);
				phase_diag_q <= phase_diag_q + 32'(rate_diag_q * ms_s1);
				palette_q    <= palette_q + 24'(rate_palette_q * ms_s1);
			end
		end
	end

	// Angle stage: keep the ROM index and the integer palette shift
	always_ff @(posedge clk) begin
		if (take_s2) begin
			for (int g = 0; g < LANES; g++) begin
				idx_s2[g] <= ang[g][31 -: SINE_INDEX_BITS];
			end
			pal_s2 <= palette_q[ppg_pkg::PAL_PHASE_BITS-1 -: ppg_pkg::PAL_BITS];
		end
	end

	// Sine ROM read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			for (int g = 0; g < LANES; g++) begin
				sine_s3[g] <= sine_tab[g][idx_s2[g]];
			end
			pal_s3 <= pal_s2;
		end
	end

	// Sum wraps mod 256, then the palette lookup into the output register
	assign pal_idx = ppg_pkg::PAL_BITS'(sine_s3[0] + sine_s3[1] + sine_s3[2] + pal_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			rgb_q <= ppg_pkg::PALETTE_ROM[pal_idx];
		end
	end

	// APB register writes
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step_q     <= ppg_pkg::COL_STEP_RST;
			row_step_q     <= ppg_pkg::ROW_STEP_RST;
			diag_step_q    <= ppg_pkg::DIAG_STEP_RST;
			rate_col_q     <= ppg_pkg::RATE_COL_RST;
			rate_row_q     <= ppg_pkg::RATE_ROW_RST;
			rate_diag_q    <= ppg_pkg::RATE_DIAG_RST;
			rate_palette_q <= ppg_pkg::RATE_PALETTE_RST;
		end else if (cfg_wr) begin
			case (ppg_pkg::reg_idx_t'(paddr[4:2]))
				ppg_pkg::REG_COL_STEP:     col_step_q     <= pwdata;
				ppg_pkg::REG_ROW_STEP:     row_step_q     <= pwdata;
				ppg_pkg::REG_DIAG_STEP:    diag_step_q    <= pwdata;
				ppg_pkg::REG_RATE_COL:     rate_col_q     <= pwdata;
				ppg_pkg::REG_RATE_ROW:     rate_row_q     <= pwdata;
				ppg_pkg::REG_RATE_DIAG:    rate_diag_q    <= pwdata;
				ppg_pkg::REG_RATE_PALETTE: rate_palette_q <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	// APB register reads
	always_comb begin
		case (ppg_pkg::reg_idx_t'(paddr[4:2]))
			ppg_pkg::REG_COL_STEP:     prdata = col_step_q;
			ppg_pkg::REG_ROW_STEP:     prdata = row_step_q;
			ppg_pkg::REG_DIAG_STEP:    prdata = diag_step_q;
			ppg_pkg::REG_RATE_COL:     prdata = rate_col_q;
			ppg_pkg::REG_RATE_ROW:     prdata = rate_row_q;
			ppg_pkg::REG_RATE_DIAG:    prdata = rate_diag_q;
			ppg_pkg::REG_RATE_PALETTE: prdata = {8'd0, rate_palette_q};
			default:                   prdata = '0;
		endcase
	end

endmodule
